>>> rtl/core/bgi_pkg.sv
// Shared types and fixed constants for the bilinear grid interpolator.
`default_nettype none

package bgi_pkg;

   localparam int ADDR_W     = 10;  // grid words per table: 1024
   localparam int CSR_ADDR_W = 4;
   localparam int CELL_W     = 8;   // cell index, at most 254
   localparam int POS_W      = 50;  // signed Q34.16 grid position (16 fraction bits)
   localparam int FRAC_W     = 26;  // clamped fraction, +-2^24
   localparam int DIFF_W     = 33;
   localparam int PROD_W     = FRAC_W + DIFF_W;
   localparam int SUM_W      = 44;

   localparam logic MODE_WRITE = 1'b0;
   localparam logic MODE_QUERY = 1'b1;

   localparam logic signed [POS_W-1:0]  FRAC_ONE     = 50'sd65536;
   localparam logic signed [POS_W-1:0]  FRAC_LIM_POS = 50'sd16777216;
   localparam logic signed [POS_W-1:0]  FRAC_LIM_NEG = -50'sd16777216;
   localparam logic signed [FRAC_W-1:0] FRAC_MAX     = 26'sd16777216;
   localparam logic signed [FRAC_W-1:0] FRAC_MIN     = -26'sd16777216;

   localparam logic signed [SUM_W-1:0] SAT_MAX = 44'sd2147483647;
   localparam logic signed [SUM_W-1:0] SAT_MIN = -44'sd2147483648;

   typedef enum logic [1:0] {
      CSR_X_ORIGIN = 2'd0,
      CSR_Y_ORIGIN = 2'd1,
      CSR_X_SCALE  = 2'd2,
      CSR_Y_SCALE  = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic                mode;
      logic [3:0]          table_sel;
      logic [ADDR_W-1:0]   entry_index;
      logic signed [31:0]  entry_value;
      logic signed [31:0]  x_coord;
      logic signed [31:0]  y_coord;
   } bgi_req_type;

   typedef struct packed {
      logic signed [31:0]  interp_value;
      logic                saturated;
   } bgi_rsp_type;

endpackage

`default_nettype wire

>>> rtl/core/bgi_store.sv
// Grid word store: one write port, two registered read ports.
`default_nettype none

module bgi_store #(
   parameter int DEPTH = 16384,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [31:0]   wr_data,
   input  logic [AW-1:0] rd_addr_a,
   input  logic [AW-1:0] rd_addr_b,
   output logic [31:0]   rd_data_a,
   output logic [31:0]   rd_data_b
);

   logic [31:0] words_ff [DEPTH];
   logic [31:0] rd_data_a_ff;
   logic [31:0] rd_data_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         words_ff[wr_addr] <= wr_data;
      end
      rd_data_a_ff <= words_ff[rd_addr_a];
      rd_data_b_ff <= words_ff[rd_addr_b];
   end

   assign rd_data_a = rd_data_a_ff;
   assign rd_data_b = rd_data_b_ff;

endmodule

`default_nettype wire

>>> rtl/core/bilinear_grid_interpolator.sv
// Bilinear grid interpolator top level: config registers, pipeline, table stores.
`default_nettype none

// One item (write or query) is taken every clock cycle; busy stays low. A write
// passes the request registers of the front pipeline to the table store, in
// order with the queries around it, so a query that follows a write sees the
// new word. A query result strobes for one cycle; the twelve stages are the
// input capture, the origin subtract, the coordinate multiply and its sum, the
// split into cell and fraction, the store read (four corner words through two
// copies of the store, two read ports each) and the three lerps (two along y
// side by side, then one along x; subtract, multiply, add each). The receiver
// cannot stall, so nothing is held back. Table words are undefined until
// written; there is no clearing pass after reset. Config registers are to be
// written only while no query is in flight; the block itself does not enforce it.

module bilinear_grid_interpolator #(
   parameter int GRID_X     = 32,
   parameter int GRID_Y     = 32,
   parameter int NUM_TABLES = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  bgi_pkg::bgi_req_type              req_item,
   output logic                              rsp_strobe,
   output bgi_pkg::bgi_rsp_type              rsp_result,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [bgi_pkg::CSR_ADDR_W-1:0]    paddr,
   input  logic [31:0]                       pwdata,
   output logic [31:0]                       prdata,
   output logic                              pready
);

   import bgi_pkg::*;

   localparam int DEPTH = NUM_TABLES * (1 << ADDR_W);
   localparam int SAW   = $clog2(DEPTH);

   localparam logic signed [POS_W-1:0] X_HI_OFS  = POS_W'((GRID_X - 2) * 65536);
   localparam logic signed [POS_W-1:0] Y_HI_OFS  = POS_W'((GRID_Y - 2) * 65536);
   localparam logic [CELL_W-1:0]       X_HI_CELL = CELL_W'(GRID_X - 2);
   localparam logic [CELL_W-1:0]       Y_HI_CELL = CELL_W'(GRID_Y - 2);

   typedef struct packed {
      logic [CELL_W-1:0]         grid_idx;
      logic signed [FRAC_W-1:0]  frac;
   } split_type;

   typedef struct packed {
      logic                clip;
      logic signed [31:0]  value;
   } lerp_type;

   // cell index clamped to [0, N-2], fraction relative to it clamped to +-256 cells
   function automatic split_type split_axis(input logic signed [POS_W-1:0] pos,
                                            input logic signed [POS_W-1:0] hi_ofs,
                                            input logic [CELL_W-1:0] hi_cell);
      logic signed [POS_W-1:0] f_hi;
      split_type r;
      f_hi = pos - hi_ofs;
      if (pos[POS_W-1]) begin
         r.grid_idx = '0;
         r.frac = (pos < FRAC_LIM_NEG) ? FRAC_MIN : FRAC_W'(pos);
      end else if (f_hi >= FRAC_ONE) begin
         r.grid_idx = hi_cell;
         r.frac = (f_hi > FRAC_LIM_POS) ? FRAC_MAX : FRAC_W'(f_hi);
      end else begin
         r.grid_idx = pos[16 +: CELL_W];
         r.frac = FRAC_W'({1'b0, pos[15:0]});
      end
      return r;
   endfunction

   function automatic lerp_type lerp_sum(input logic signed [31:0] a,
                                         input logic signed [PROD_W-1:0] p);
      logic signed [SUM_W-1:0] s;
      lerp_type r;
      s = SUM_W'(a) + SUM_W'(p >>> 16);
      if (s > SAT_MAX) begin
         r.clip  = 1'b1;
         r.value = 32'sh7fffffff;
      end else if (s < SAT_MIN) begin
         r.clip  = 1'b1;
         r.value = 32'sh80000000;
      end else begin
         r.clip  = 1'b0;
         r.value = s[31:0];
      end
      return r;
   endfunction

   // ---------------- configuration registers ----------------
   logic signed [31:0] x_origin_ff;
   logic signed [31:0] y_origin_ff;
   logic [31:0]        x_scale_ff;
   logic [31:0]        y_scale_ff;
   csr_index_type      csr_sel;
   logic               csr_write;

   assign csr_sel   = csr_index_type'(paddr[3:2]);
   assign csr_write = psel & penable & pwrite;
   assign pready    = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         x_origin_ff <= '0;
         y_origin_ff <= '0;
         x_scale_ff  <= 32'd65536;
         y_scale_ff  <= 32'd65536;
      end else if (csr_write) begin
         unique case (csr_sel)
            CSR_X_ORIGIN: x_origin_ff <= pwdata;
            CSR_Y_ORIGIN: y_origin_ff <= pwdata;
            CSR_X_SCALE:  x_scale_ff  <= pwdata;
            CSR_Y_SCALE:  y_scale_ff  <= pwdata;
            default:      x_scale_ff  <= x_scale_ff;
         endcase
      end
   end

   always_comb begin
      unique case (csr_sel)
         CSR_X_ORIGIN: prdata = x_origin_ff;
         CSR_Y_ORIGIN: prdata = y_origin_ff;
         CSR_X_SCALE:  prdata = x_scale_ff;
         CSR_Y_SCALE:  prdata = y_scale_ff;
         default:      prdata = '0;
      endcase
   end

   // ---------------- front pipeline: position and cell ----------------
   logic        accept;
   bgi_req_type req0_ff, req1_ff, req2_ff, req3_ff, req4_ff;
   logic        v0_ff, v1_ff, v2_ff, v3_ff, v4_ff;

   logic signed [DIFF_W-1:0] dx_in, dy_in, dx_ff, dy_ff;
   logic signed [POS_W-1:0]  px_lo_in, px_hi_in, py_lo_in, py_hi_in;
   logic signed [POS_W-1:0]  px_lo_ff, px_hi_ff, py_lo_ff, py_hi_ff;
   logic signed [POS_W-1:0]  posx_in, posy_in, posx_ff, posy_ff;
   split_type                sx_in, sy_in, sx_ff, sy_ff;

   assign busy   = 1'b0;
   assign accept = start & ~busy;

   assign dx_in = DIFF_W'(req0_ff.x_coord) - DIFF_W'(x_origin_ff);
   assign dy_in = DIFF_W'(req0_ff.y_coord) - DIFF_W'(y_origin_ff);

   // scale split in 16-bit halves: pos = d*hi + floor(d*lo / 2^16)
   assign px_lo_in = dx_ff * $signed({1'b0, x_scale_ff[15:0]});
   assign px_hi_in = dx_ff * $signed({1'b0, x_scale_ff[31:16]});
   assign py_lo_in = dy_ff * $signed({1'b0, y_scale_ff[15:0]});
   assign py_hi_in = dy_ff * $signed({1'b0, y_scale_ff[31:16]});

   assign posx_in = px_hi_ff + (px_lo_ff >>> 16);
   assign posy_in = py_hi_ff + (py_lo_ff >>> 16);

   assign sx_in = split_axis(posx_ff, X_HI_OFS, X_HI_CELL);
   assign sy_in = split_axis(posy_ff, Y_HI_OFS, Y_HI_CELL);

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         v0_ff <= accept;
         v1_ff <= v0_ff;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      req0_ff  <= req_item;
      req1_ff  <= req0_ff;
      req2_ff  <= req1_ff;
      req3_ff  <= req2_ff;
      req4_ff  <= req3_ff;
      dx_ff    <= dx_in;
      dy_ff    <= dy_in;
      px_lo_ff <= px_lo_in;
      px_hi_ff <= px_hi_in;
      py_lo_ff <= py_lo_in;
      py_hi_ff <= py_hi_in;
      posx_ff  <= posx_in;
      posy_ff  <= posy_in;
      sx_ff    <= sx_in;
      sy_ff    <= sy_in;
   end

   // ---------------- store access ----------------
   // Writes and reads happen at the same stage, so item order is kept.
   logic              sel_ok;
   logic              wr_en;
   logic [SAW-1:0]    wr_addr;
   logic [ADDR_W-1:0] a00, a01, a10, a11;
   logic [31:0]       rd00, rd01, rd10, rd11;

   assign sel_ok  = {1'b0, req4_ff.table_sel} < 5'(NUM_TABLES);
   assign wr_en   = v4_ff & (req4_ff.mode == MODE_WRITE) & sel_ok;
   assign wr_addr = SAW'({req4_ff.table_sel, req4_ff.entry_index});

   assign a00 = ADDR_W'(int'(sx_ff.grid_idx) * GRID_Y + int'(sy_ff.grid_idx));
   assign a01 = ADDR_W'(int'(sx_ff.grid_idx) * GRID_Y + int'(sy_ff.grid_idx) + 1);
   assign a10 = ADDR_W'(int'(sx_ff.grid_idx) * GRID_Y + int'(sy_ff.grid_idx) + GRID_Y);
   assign a11 = ADDR_W'(int'(sx_ff.grid_idx) * GRID_Y + int'(sy_ff.grid_idx) + GRID_Y + 1);

   bgi_store #(
      .DEPTH(DEPTH)
   ) u_store_left (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (req4_ff.entry_value),
      .rd_addr_a (SAW'({req4_ff.table_sel, a00})),
      .rd_addr_b (SAW'({req4_ff.table_sel, a01})),
      .rd_data_a (rd00),
      .rd_data_b (rd01)
   );

   bgi_store #(
      .DEPTH(DEPTH)
   ) u_store_right (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (req4_ff.entry_value),
      .rd_addr_a (SAW'({req4_ff.table_sel, a10})),
      .rd_addr_b (SAW'({req4_ff.table_sel, a11})),
      .rd_data_a (rd10),
      .rd_data_b (rd11)
   );

   // ---------------- back pipeline: three lerps ----------------
   logic v5_ff, v6_ff, v7_ff, v8_ff, v9_ff, v10_ff;
   logic bad5_ff, bad6_ff, bad7_ff, bad8_ff, bad9_ff, bad10_ff;
   logic signed [FRAC_W-1:0] tx5_ff, tx6_ff, tx7_ff, tx8_ff, tx9_ff;
   logic signed [FRAC_W-1:0] ty5_ff, ty6_ff;

   logic signed [31:0]       r00, r01, r10, r11;
   logic signed [DIFF_W-1:0] d0_in, d1_in, d0_ff, d1_ff;
   logic signed [31:0]       a0_6_ff, a1_6_ff, a0_7_ff, a1_7_ff;
   logic signed [PROD_W-1:0] p0_in, p1_in, p0_ff, p1_ff;
   lerp_type                 zl_in, zr_in, zl8_ff, zr8_ff;
   logic signed [31:0]       zl9_ff, zl10_ff;
   logic signed [DIFF_W-1:0] dz_in, dz_ff;
   logic                     clip9_ff, clip10_ff;
   logic signed [PROD_W-1:0] px_in, px_ff;
   lerp_type                 v_in;
   logic                     rsp_strobe_ff;
   bgi_rsp_type              rsp_result_ff;

   assign r00 = rd00;
   assign r01 = rd01;
   assign r10 = rd10;
   assign r11 = rd11;

   assign d0_in = DIFF_W'(r01) - DIFF_W'(r00);
   assign d1_in = DIFF_W'(r11) - DIFF_W'(r10);
   assign p0_in = ty6_ff * d0_ff;
   assign p1_in = ty6_ff * d1_ff;
   assign zl_in = lerp_sum(a0_7_ff, p0_ff);
   assign zr_in = lerp_sum(a1_7_ff, p1_ff);
   assign dz_in = DIFF_W'(zr8_ff.value) - DIFF_W'(zl8_ff.value);
   assign px_in = tx9_ff * dz_ff;
   assign v_in  = lerp_sum(zl10_ff, px_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         v5_ff         <= 1'b0;
         v6_ff         <= 1'b0;
         v7_ff         <= 1'b0;
         v8_ff         <= 1'b0;
         v9_ff         <= 1'b0;
         v10_ff        <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         v5_ff         <= v4_ff & (req4_ff.mode == MODE_QUERY);
         v6_ff         <= v5_ff;
         v7_ff         <= v6_ff;
         v8_ff         <= v7_ff;
         v9_ff         <= v8_ff;
         v10_ff        <= v9_ff;
         rsp_strobe_ff <= v10_ff;
      end
   end

   always_ff @(posedge clock) begin
      bad5_ff   <= ~sel_ok;
      tx5_ff    <= sx_ff.frac;
      ty5_ff    <= sy_ff.frac;

      bad6_ff   <= bad5_ff;
      tx6_ff    <= tx5_ff;
      ty6_ff    <= ty5_ff;
      a0_6_ff   <= r00;
      a1_6_ff   <= r10;
      d0_ff     <= d0_in;
      d1_ff     <= d1_in;

      bad7_ff   <= bad6_ff;
      tx7_ff    <= tx6_ff;
      a0_7_ff   <= a0_6_ff;
      a1_7_ff   <= a1_6_ff;
      p0_ff     <= p0_in;
      p1_ff     <= p1_in;

      bad8_ff   <= bad7_ff;
      tx8_ff    <= tx7_ff;
      zl8_ff    <= zl_in;
      zr8_ff    <= zr_in;

      bad9_ff   <= bad8_ff;
      tx9_ff    <= tx8_ff;
      zl9_ff    <= zl8_ff.value;
      dz_ff     <= dz_in;
      clip9_ff  <= zl8_ff.clip | zr8_ff.clip;

      bad10_ff  <= bad9_ff;
      zl10_ff   <= zl9_ff;
      px_ff     <= px_in;
      clip10_ff <= clip9_ff;

      // a table number past the last table answers zero, unflagged
      rsp_result_ff.interp_value <= bad10_ff ? 32'sd0 : v_in.value;
      rsp_result_ff.saturated    <= ~bad10_ff & (clip10_ff | v_in.clip);
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_result = rsp_result_ff;

endmodule

`default_nettype wire
